// ----- sv/ack_timeout_retry_link_assert.svh -----
// ----------------------------------------------------------------------------
// ack_timeout_retry_link_assert.svh
// Assertion macros used by the link RTL.
// ----------------------------------------------------------------------------
`ifndef ACK_TIMEOUT_RETRY_LINK_ASSERT_SVH
`define ACK_TIMEOUT_RETRY_LINK_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define ATRL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ATRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/atrl_pkg.sv -----
// ----------------------------------------------------------------------------
// atrl_pkg
// Codes, widths, reset values and the result type of the command link.
// ----------------------------------------------------------------------------
package atrl_pkg;

    localparam int OP_W     = 3;
    localparam int MT_W     = 3;
    localparam int ID_W     = 32;
    localparam int BOX_W    = 8;
    localparam int CH_W     = 8;
    localparam int TIME_W   = 32;
    localparam int NONCE_W  = 32;
    localparam int TMO_W    = 16;
    localparam int RETRY_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_FIRE      = 3'd0;
    localparam logic [OP_W-1:0] OP_ACK       = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK      = 3'd2;
    localparam logic [OP_W-1:0] OP_ARM       = 3'd3;
    localparam logic [OP_W-1:0] OP_DISARM    = 3'd4;
    localparam logic [OP_W-1:0] OP_ESTOP     = 3'd5;
    localparam logic [OP_W-1:0] OP_HEARTBEAT = 3'd6;

    // packet message types
    localparam logic [MT_W-1:0] MT_FIRE      = 3'd0;
    localparam logic [MT_W-1:0] MT_ARM       = 3'd1;
    localparam logic [MT_W-1:0] MT_DISARM    = 3'd2;
    localparam logic [MT_W-1:0] MT_ESTOP     = 3'd3;
    localparam logic [MT_W-1:0] MT_HEARTBEAT = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd1;

    localparam logic [TMO_W-1:0]   TIMEOUT_RST = 16'd500;
    localparam logic [RETRY_W-1:0] RETRIES_RST = 8'd3;
    localparam logic [ID_W-1:0]    SEQ_ID_RST  = 32'd1;

    typedef struct packed {
        logic                 send_valid;
        logic [MT_W-1:0]      msg_type;
        logic [ID_W-1:0]      packet_id;
        logic [BOX_W-1:0]     dest_box;
        logic [CH_W-1:0]      target_channel;
        logic [NONCE_W-1:0]   packet_nonce;
        logic [ID_W-1:0]      assigned_id;
        logic                 pending;
        logic [ID_W-1:0]      last_failed_id;
    } t_result;

endpackage

// ----- sv/atrl_if.sv -----
// ----------------------------------------------------------------------------
// atrl_if
// Valid/ready channels of the command link: commands, results, config.
// ----------------------------------------------------------------------------
interface atrl_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [atrl_pkg::OP_W-1:0]     operation;
    logic [atrl_pkg::BOX_W-1:0]    box_id;
    logic [atrl_pkg::CH_W-1:0]     channel;
    logic [atrl_pkg::TIME_W-1:0]   now_ms;
    logic [atrl_pkg::NONCE_W-1:0]  nonce;
    logic [atrl_pkg::ID_W-1:0]     response_id;

    modport source (output valid, operation, box_id, channel, now_ms, nonce,
                    response_id, input ready);
    modport sink   (input valid, operation, box_id, channel, now_ms, nonce,
                    response_id, output ready);
endinterface

interface atrl_res_if;
    logic                          valid;
    logic                          ready;
    logic                          send_valid;
    logic [atrl_pkg::MT_W-1:0]     msg_type;
    logic [atrl_pkg::ID_W-1:0]     packet_id;
    logic [atrl_pkg::BOX_W-1:0]    dest_box;
    logic [atrl_pkg::CH_W-1:0]     target_channel;
    logic [atrl_pkg::NONCE_W-1:0]  packet_nonce;
    logic [atrl_pkg::ID_W-1:0]     assigned_id;
    logic                          pending;
    logic [atrl_pkg::ID_W-1:0]     last_failed_id;

    modport source (output valid, send_valid, msg_type, packet_id, dest_box,
                    target_channel, packet_nonce, assigned_id, pending,
                    last_failed_id, input ready);
    modport sink   (input valid, send_valid, msg_type, packet_id, dest_box,
                    target_channel, packet_nonce, assigned_id, pending,
                    last_failed_id, output ready);
endinterface

interface atrl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [atrl_pkg::CFG_IDX_W-1:0]   index;
    logic [atrl_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/atrl_outq.sv -----
// ----------------------------------------------------------------------------
// atrl_outq
// Two-entry result queue; keeps the command side moving while the
// result receiver stalls, until both entries are full.
// ----------------------------------------------------------------------------
module atrl_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  atrl_pkg::t_result i_data,
    output logic              o_full,
    atrl_res_if.source        o_res
);

    atrl_pkg::t_result r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;
    atrl_pkg::t_result head;

    assign pop    = o_res.valid & o_res.ready;
    assign o_full = (r_cnt == 2'd2);
    assign head   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_cnt    = r_cnt + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_res.valid          = (r_cnt != 2'd0);
    assign o_res.send_valid     = head.send_valid;
    assign o_res.msg_type       = head.msg_type;
    assign o_res.packet_id      = head.packet_id;
    assign o_res.dest_box       = head.dest_box;
    assign o_res.target_channel = head.target_channel;
    assign o_res.packet_nonce   = head.packet_nonce;
    assign o_res.assigned_id    = head.assigned_id;
    assign o_res.pending        = head.pending;
    assign o_res.last_failed_id = head.last_failed_id;

endmodule

// ----- sv/ack_timeout_retry_link.sv -----
// ----------------------------------------------------------------------------
// ack_timeout_retry_link
// Stop-and-wait command sender with ack timeout and a bounded retry count.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd  : one operation per transfer (fire, ack, tick, arm, disarm,
//            estop, heartbeat). Every transfer yields exactly one result.
//   o_res  : packet fields plus status (pending flag, last failed id).
//            send_valid low means no packet this time, status only.
//   i_cfg  : register writes (0 ack timeout in ms, 1 max retries), always
//            ready; write only while no command is in flight.
// Timing:
//   A result is visible on o_res the cycle after its command transfer when
//   no earlier result waits in the queue. One command per cycle is sustained
//   while the result queue is not full; the whole update (id increment, one
//   32-bit elapsed-time subtract and compare) sits between the command
//   transfer and the result queue.
// Reset (synchronous, active low): sequence id 1, nothing pending, failed id 0,
//   timeout 500 ms, 3 retries, result queue empty. Stall: a two-entry result
//   queue absorbs one extra command while o_res is held; i_cmd.ready drops only when both entries are full.
// ----------------------------------------------------------------------------
`include "ack_timeout_retry_link_assert.svh"

module ack_timeout_retry_link (
    input  logic       i_clk,
    input  logic       i_rst_n,
    atrl_cmd_if.sink   i_cmd,
    atrl_cfg_if.sink   i_cfg,
    atrl_res_if.source o_res
);

    logic [atrl_pkg::TMO_W-1:0]   r_timeout;
    logic [atrl_pkg::RETRY_W-1:0] r_max_retries;

    logic [atrl_pkg::ID_W-1:0]    r_next_id,   n_next_id;
    logic [atrl_pkg::ID_W-1:0]    r_pend_id,   n_pend_id;
    logic [atrl_pkg::BOX_W-1:0]   r_pend_box,  n_pend_box;
    logic [atrl_pkg::CH_W-1:0]    r_pend_ch,   n_pend_ch;
    logic [atrl_pkg::TIME_W-1:0]  r_last_time, n_last_time;
    logic [atrl_pkg::RETRY_W-1:0] r_retry_cnt, n_retry_cnt;
    logic [atrl_pkg::ID_W-1:0]    r_failed_id, n_failed_id;

    logic                          in_acc;
    logic                          q_full;
    logic                          pend_live;
    logic                          expired;
    logic                          takes_id;
    logic [atrl_pkg::TIME_W-1:0]   elapsed;
    atrl_pkg::t_result             res;

    assign in_acc      = i_cmd.valid & i_cmd.ready;
    assign i_cmd.ready = ~q_full;
    assign i_cfg.ready = 1'b1;

    assign pend_live = (r_pend_id != '0);
    assign elapsed   = i_cmd.now_ms - r_last_time;
    assign expired   = (elapsed >= {{(atrl_pkg::TIME_W-atrl_pkg::TMO_W){1'b0}}, r_timeout});
    assign takes_id  = (i_cmd.operation == atrl_pkg::OP_FIRE)
                    || (i_cmd.operation == atrl_pkg::OP_ARM)
                    || (i_cmd.operation == atrl_pkg::OP_DISARM)
                    || (i_cmd.operation == atrl_pkg::OP_ESTOP)
                    || (i_cmd.operation == atrl_pkg::OP_HEARTBEAT);

    always_comb begin
        n_next_id   = r_next_id;
        n_pend_id   = r_pend_id;
        n_pend_box  = r_pend_box;
        n_pend_ch   = r_pend_ch;
        n_last_time = r_last_time;
        n_retry_cnt = r_retry_cnt;
        n_failed_id = r_failed_id;
        res         = '0;

        unique case (i_cmd.operation)
            atrl_pkg::OP_FIRE: begin
                n_next_id          = r_next_id + 1'b1;
                n_pend_id          = r_next_id;
                n_pend_box         = i_cmd.box_id;
                n_pend_ch          = i_cmd.channel;
                n_last_time        = i_cmd.now_ms;
                n_retry_cnt        = '0;
                res.send_valid     = 1'b1;
                res.msg_type       = atrl_pkg::MT_FIRE;
                res.packet_id      = r_next_id;
                res.dest_box       = i_cmd.box_id;
                res.target_channel = i_cmd.channel;
                res.assigned_id    = r_next_id;
            end
            atrl_pkg::OP_ACK: begin
                if (pend_live && (i_cmd.response_id == r_pend_id)) begin
                    n_pend_id = '0;
                end
            end
            atrl_pkg::OP_TICK: begin
                if (pend_live && expired) begin
                    if (r_retry_cnt < r_max_retries) begin
                        n_retry_cnt        = r_retry_cnt + 1'b1;
                        n_last_time        = i_cmd.now_ms;
                        res.send_valid     = 1'b1;
                        res.msg_type       = atrl_pkg::MT_FIRE;
                        res.packet_id      = r_pend_id;
                        res.dest_box       = r_pend_box;
                        res.target_channel = r_pend_ch;
                    end else begin
                        n_failed_id = r_pend_id;
                        n_pend_id   = '0;
                    end
                end
            end
            atrl_pkg::OP_ARM: begin
                n_next_id        = r_next_id + 1'b1;
                res.send_valid   = 1'b1;
                res.msg_type     = atrl_pkg::MT_ARM;
                res.packet_id    = r_next_id;
                res.packet_nonce = i_cmd.nonce;
            end
            atrl_pkg::OP_DISARM: begin
                n_next_id      = r_next_id + 1'b1;
                res.send_valid = 1'b1;
                res.msg_type   = atrl_pkg::MT_DISARM;
                res.packet_id  = r_next_id;
            end
            atrl_pkg::OP_ESTOP: begin
                n_next_id      = r_next_id + 1'b1;
                res.send_valid = 1'b1;
                res.msg_type   = atrl_pkg::MT_ESTOP;
                res.packet_id  = r_next_id;
            end
            atrl_pkg::OP_HEARTBEAT: begin
                n_next_id      = r_next_id + 1'b1;
                res.send_valid = 1'b1;
                res.msg_type   = atrl_pkg::MT_HEARTBEAT;
                res.packet_id  = r_next_id;
            end
            default: begin
                // unused code: status only
            end
        endcase

        // a fire that draws id zero is sent but not tracked (zero means none)
        res.pending        = (n_pend_id != '0);
        res.last_failed_id = n_failed_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id   <= atrl_pkg::SEQ_ID_RST;
            r_pend_id   <= '0;
            r_pend_box  <= '0;
            r_pend_ch   <= '0;
            r_last_time <= '0;
            r_retry_cnt <= '0;
            r_failed_id <= '0;
        end else if (in_acc) begin
            r_next_id   <= n_next_id;
            r_pend_id   <= n_pend_id;
            r_pend_box  <= n_pend_box;
            r_pend_ch   <= n_pend_ch;
            r_last_time <= n_last_time;
            r_retry_cnt <= n_retry_cnt;
            r_failed_id <= n_failed_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= atrl_pkg::TIMEOUT_RST;
            r_max_retries <= atrl_pkg::RETRIES_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == atrl_pkg::CFG_ACK_TIMEOUT) begin
                r_timeout <= i_cfg.data;
            end
            if (i_cfg.index == atrl_pkg::CFG_MAX_RETRIES) begin
                r_max_retries <= i_cfg.data[atrl_pkg::RETRY_W-1:0];
            end
        end
    end

    atrl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc),
        .i_data  (res),
        .o_full  (q_full),
        .o_res   (o_res)
    );

    `ATRL_ASSERT_NEXT(a_id_advance, in_acc && takes_id,
        r_next_id == $past(r_next_id) + 1'b1, "sequence id did not advance")
    `ATRL_ASSERT_NEXT(a_id_hold, in_acc && !takes_id,
        $stable(r_next_id), "sequence id moved without a new packet")
    `ATRL_ASSERT_NEXT(a_ack_clears,
        in_acc && (i_cmd.operation == atrl_pkg::OP_ACK) && pend_live
            && (i_cmd.response_id == r_pend_id),
        r_pend_id == '0, "matching ack left command pending")
    `ATRL_ASSERT_NOW(a_fail_no_packet,
        in_acc && (n_failed_id != r_failed_id),
        !res.send_valid && (n_pend_id == '0), "give-up emitted a packet")

endmodule
